/* src/axis_angle_to_rotation_matrix_macros.svh */
// Assertion macros for the axis-angle to rotation matrix block.
// Clocked on clk; the SYNTH build turns every check into nothing.
`ifndef AXIS_ANGLE_TO_ROTATION_MATRIX_MACROS_SVH
`define AXIS_ANGLE_TO_ROTATION_MATRIX_MACROS_SVH
`ifndef SYNTH
// check while out of reset
`define AAR_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("aar: check failed");
// check that also covers the reset cycles
`define AAR_ASSERT_RST(label, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("aar: reset check failed");
`else
`define AAR_ASSERT(label, prop)
`define AAR_ASSERT_RST(label, prop)
`endif
`endif

/* src/aar_pkg.sv */
// Shared constants, tables and types for the axis-angle to rotation matrix block.
// No dependencies; aar_cordic, aar_sqrt, aar_div, aar_matrix and the top use it by scoped names.
`default_nettype none
package aar_pkg;

  localparam int AXIS_W  = 16;
  localparam int ENTRY_W = 16;
  localparam int ENTRIES = 9;

  // CORDIC in Q.28, one rotation per stage
  localparam int CORDIC_STEPS = 20;
  localparam int CORDIC_W     = 32;
  localparam logic signed [CORDIC_W-1:0] FIX_PI      = 32'sd843314857;
  localparam logic signed [CORDIC_W-1:0] FIX_HALF_PI = 32'sd421657428;
  localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN = 32'sd163008219;
  localparam logic signed [CORDIC_W-1:0] ATAN_TAB [CORDIC_STEPS] = '{
    32'sd210828714, 32'sd124459457, 32'sd65760959, 32'sd33381290, 32'sd16755422,
    32'sd8385879,   32'sd4193963,   32'sd2097109,  32'sd1048571,  32'sd524287,
    32'sd262144,    32'sd131072,    32'sd65536,    32'sd32768,    32'sd16384,
    32'sd8192,      32'sd4096,      32'sd2048,     32'sd1024,     32'sd512
  };

  // square root of n2 * 2^32, one root bit per stage
  localparam int N2_W       = 32;
  localparam int SQRT_STEPS = 32;
  localparam int ROOT_W     = 32;
  localparam int SREM_W     = 33;

  // axis / length, one quotient bit per stage
  localparam int MAG_W     = 16;
  localparam int DIV_STEPS = 29;
  localparam int QUOT_W    = 29;

  localparam int FRONT_STAGES = 2;
  localparam int MAT_STAGES   = 6;
  localparam int PIPE_DEPTH   = FRONT_STAGES + SQRT_STEPS + DIV_STEPS + MAT_STAGES;
  localparam int CORDIC_ALIGN = SQRT_STEPS + DIV_STEPS - CORDIC_STEPS;
  localparam int SIDE_ALIGN   = SQRT_STEPS + DIV_STEPS;

  localparam logic signed [ENTRY_W-1:0] ONE_Q14 = 16'sd16384;
  localparam logic [ENTRIES*ENTRY_W-1:0] IDENTITY_DATA = {
    16'd16384, 16'd0, 16'd0, 16'd0, 16'd16384, 16'd0, 16'd0, 16'd0, 16'd16384
  };

  // per-item side information that rides along the long stages
  typedef struct packed {
    logic signed [AXIS_W-1:0] ax;
    logic signed [AXIS_W-1:0] ay;
    logic signed [AXIS_W-1:0] az;
    logic [2:0]               neg;
    logic                     norm;
    logic                     degen;
    logic                     flip;
  } side_t;

endpackage
`default_nettype wire

/* src/aar_delay.sv */
// Enabled shift-register delay line for data that rides beside the long stages.
// Standalone; width and depth come from the instantiating module.
`default_nettype none
module aar_delay #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 1
) (
  input  wire logic             clk,
  input  wire logic             ce,
  input  wire logic [WIDTH-1:0] din,
  output logic      [WIDTH-1:0] dout
);

  logic [WIDTH-1:0] taps [DEPTH];

  // advance all taps together
  always_ff @(posedge clk) begin
    if (ce) begin
      taps[0] <= din;
      for (int k = 1; k < DEPTH; k++) begin
        taps[k] <= taps[k-1];
      end
    end
  end

  assign dout = taps[DEPTH-1];

endmodule
`default_nettype wire

/* src/aar_cordic.sv */
// Pipelined rotation-mode CORDIC: one micro-rotation per register stage.
// Uses aar_pkg for the gain, the arctangent table and widths.
`default_nettype none
module aar_cordic (
  input  wire logic                                  clk,
  input  wire logic                                  ce,
  input  wire logic signed [aar_pkg::CORDIC_W-1:0]   z_in,
  output logic signed      [aar_pkg::CORDIC_W-1:0]   cos_out,
  output logic signed      [aar_pkg::CORDIC_W-1:0]   sin_out
);

  localparam int N = aar_pkg::CORDIC_STEPS;
  localparam int W = aar_pkg::CORDIC_W;

  logic signed [W-1:0] xs [N+1];
  logic signed [W-1:0] ys [N+1];
  logic signed [W-1:0] zs [N];

  assign xs[0] = aar_pkg::CORDIC_GAIN;
  assign ys[0] = '0;
  assign zs[0] = z_in;

  for (genvar i = 0; i < N; i++) begin : g_step
    logic signed [W-1:0] dx;
    logic signed [W-1:0] dy;
    assign dx = xs[i] >>> i;
    assign dy = xs[i] >>> i;

    // rotate toward zero residual angle
    always_ff @(posedge clk) begin
      if (ce) begin
        if (!zs[i][W-1]) begin
          xs[i+1] <= xs[i] - (ys[i] >>> i);
          ys[i+1] <= ys[i] + dy;
        end else begin
          xs[i+1] <= xs[i] + (ys[i] >>> i);
          ys[i+1] <= ys[i] - dx;
        end
      end
    end

    if (i < N - 1) begin : g_z
      always_ff @(posedge clk) begin
        if (ce) begin
          zs[i+1] <= zs[i][W-1] ? zs[i] + aar_pkg::ATAN_TAB[i]
                                : zs[i] - aar_pkg::ATAN_TAB[i];
        end
      end
    end
  end

  assign cos_out = xs[N];
  assign sin_out = ys[N];

endmodule
`default_nettype wire

/* src/aar_sqrt.sv */
// Pipelined integer square root of n2 * 2^32, one root bit per stage.
// Uses aar_pkg for widths and step count.
`default_nettype none
module aar_sqrt (
  input  wire logic                         clk,
  input  wire logic                         ce,
  input  wire logic [aar_pkg::N2_W-1:0]     n2,
  output logic      [aar_pkg::ROOT_W-1:0]   root_out
);

  localparam int N  = aar_pkg::SQRT_STEPS;
  localparam int RW = aar_pkg::ROOT_W;
  localparam int SW = aar_pkg::SREM_W;
  localparam int NW = aar_pkg::N2_W;

  logic [SW-1:0] rems [N];
  logic [RW-1:0] roots [N+1];
  logic [NW-1:0] rads [N];

  assign rems[0]  = '0;
  assign roots[0] = '0;
  assign rads[0]  = n2;

  for (genvar i = 0; i < N; i++) begin : g_step
    logic [SW+1:0] trial_rem;
    logic [SW+1:0] trial;
    logic          fits;
    assign trial_rem = {rems[i], rads[i][NW-1:NW-2]};
    // candidate (2r+1)^2 - 4r^2 = 4r + 1
    assign trial     = {{(SW-RW){1'b0}}, roots[i], 2'b01};
    assign fits      = (trial_rem >= trial);

    // settle one root bit
    always_ff @(posedge clk) begin
      if (ce) begin
        roots[i+1] <= {roots[i][RW-2:0], fits};
      end
    end

    if (i < N - 1) begin : g_rem
      always_ff @(posedge clk) begin
        if (ce) begin
          rems[i+1] <= fits ? SW'(trial_rem - trial) : SW'(trial_rem);
          rads[i+1] <= {rads[i][NW-3:0], 2'b00};
        end
      end
    end
  end

  assign root_out = roots[N];

endmodule
`default_nettype wire

/* src/aar_div.sv */
// Three-lane pipelined restoring divider: magnitude * 2^44 / length.
// Uses aar_pkg for widths and step count.
`default_nettype none
module aar_div (
  input  wire logic                         clk,
  input  wire logic                         ce,
  input  wire logic [aar_pkg::ROOT_W-1:0]   len,
  input  wire logic [aar_pkg::MAG_W-1:0]    mag [3],
  output logic      [aar_pkg::QUOT_W-1:0]   quot [3]
);

  localparam int N  = aar_pkg::DIV_STEPS;
  localparam int RW = aar_pkg::ROOT_W;
  localparam int QW = aar_pkg::QUOT_W;
  localparam int MW = aar_pkg::MAG_W;

  logic [RW-1:0] lens [N];
  assign lens[0] = len;

  // carry the divisor down the stages
  for (genvar k = 0; k < N - 1; k++) begin : g_len
    always_ff @(posedge clk) begin
      if (ce) begin
        lens[k+1] <= lens[k];
      end
    end
  end

  for (genvar l = 0; l < 3; l++) begin : g_lane
    logic [RW-1:0] rems [N];
    logic [QW-1:0] qts [N+1];

    // the dividend's low bits are zero, so start from mag shifted up
    assign rems[0] = {{(RW-MW-15){1'b0}}, mag[l], 15'b0};
    assign qts[0]  = '0;

    for (genvar k = 0; k < N; k++) begin : g_step
      logic [RW:0] shifted;
      logic        fits;
      assign shifted = {rems[k], 1'b0};
      assign fits    = (shifted >= {1'b0, lens[k]});

      always_ff @(posedge clk) begin
        if (ce) begin
          qts[k+1] <= {qts[k][QW-2:0], fits};
        end
      end

      if (k < N - 1) begin : g_rem
        always_ff @(posedge clk) begin
          if (ce) begin
            rems[k+1] <= fits ? RW'(shifted - {1'b0, lens[k]}) : RW'(shifted);
          end
        end
      end
    end

    assign quot[l] = qts[N];
  end

endmodule
`default_nettype wire

/* src/aar_matrix.sv */
// Quaternion build and expansion into a saturated Q2.14 rotation matrix.
// Six register stages; uses aar_pkg for widths, side_t and the identity value.
`default_nettype none
module aar_matrix (
  input  wire logic                                 clk,
  input  wire logic                                 ce,
  input  wire logic [aar_pkg::QUOT_W-1:0]           quot [3],
  input  wire aar_pkg::side_t                       side,
  input  wire logic signed [aar_pkg::CORDIC_W-1:0]  cos_in,
  input  wire logic signed [aar_pkg::CORDIC_W-1:0]  sin_in,
  output logic signed [aar_pkg::ENTRY_W-1:0]        r [aar_pkg::ENTRIES],
  output logic                                      degenerate
);

  localparam int CW = aar_pkg::CORDIC_W;
  localparam int EW = aar_pkg::ENTRY_W;

  function automatic logic signed [61:0] dbl(input logic signed [29:0] a,
                                              input logic signed [29:0] b);
    logic signed [59:0] p;
    p = a * b;
    return {p[59], p, 1'b0};
  endfunction

  function automatic logic signed [EW-1:0] sat16(input logic signed [63:0] e);
    logic signed [63:0] t;
    t = (e + (64'sd1 <<< 33)) >>> 34;
    if (t > 64'sd32767) begin
      return 16'sh7fff;
    end else if (t < -64'sd32768) begin
      return 16'sh8000;
    end
    return t[EW-1:0];
  endfunction

  logic signed [31:0] u_a [3];
  logic signed [CW-1:0] cs_a, sn_a;
  logic signed [63:0] p_b [3];
  logic signed [27:0] w_b, w_c;
  logic signed [29:0] q_c [3];
  logic signed [61:0] pd [9];
  logic signed [63:0] e_e [aar_pkg::ENTRIES];
  logic deg_a, deg_b, deg_c, deg_d, deg_e;
  logic signed [CW-1:0] cs_round;

  assign cs_round = cs_a + 32'sd8;

  always_ff @(posedge clk) begin
    if (ce) begin
      // stage A: signed axis, folded cosine and sine
      for (int l = 0; l < 3; l++) begin
        if (side.norm) begin
          u_a[l] <= side.neg[l] ? -$signed({3'b000, quot[l]})
                                :  $signed({3'b000, quot[l]});
        end else begin
          u_a[l] <= l == 0 ? {side.ax, 16'b0} :
                    l == 1 ? {side.ay, 16'b0} : {side.az, 16'b0};
        end
      end
      cs_a  <= side.flip ? -cos_in : cos_in;
      sn_a  <= side.flip ? -sin_in : sin_in;
      deg_a <= side.degen;

      // stage B: axis times sine, round the cosine
      for (int l = 0; l < 3; l++) begin
        p_b[l] <= 64'(u_a[l]) * 64'(sn_a);
      end
      w_b   <= 28'(cs_round >>> 4);
      deg_b <= deg_a;

      // stage C: round to Q.24 quaternion
      for (int l = 0; l < 3; l++) begin
        q_c[l] <= 30'((p_b[l] + (64'sd1 <<< 31)) >>> 32);
      end
      w_c   <= w_b;
      deg_c <= deg_b;

      // stage D: doubled pair products
      pd[0] <= dbl(q_c[0], q_c[0]);
      pd[1] <= dbl(q_c[1], q_c[1]);
      pd[2] <= dbl(q_c[2], q_c[2]);
      pd[3] <= dbl(q_c[0], q_c[1]);
      pd[4] <= dbl(q_c[0], q_c[2]);
      pd[5] <= dbl(q_c[1], q_c[2]);
      pd[6] <= dbl(30'(w_c), q_c[0]);
      pd[7] <= dbl(30'(w_c), q_c[1]);
      pd[8] <= dbl(30'(w_c), q_c[2]);
      deg_d <= deg_c;

      // stage E: matrix entries in Q.48 (xx yy zz xy xz yz wx wy wz)
      e_e[0] <= (64'sd1 <<< 48) - (64'(pd[1]) + 64'(pd[2]));
      e_e[1] <= 64'(pd[3]) + 64'(pd[8]);
      e_e[2] <= 64'(pd[4]) - 64'(pd[7]);
      e_e[3] <= 64'(pd[3]) - 64'(pd[8]);
      e_e[4] <= (64'sd1 <<< 48) - (64'(pd[0]) + 64'(pd[2]));
      e_e[5] <= 64'(pd[5]) + 64'(pd[6]);
      e_e[6] <= 64'(pd[4]) + 64'(pd[7]);
      e_e[7] <= 64'(pd[5]) - 64'(pd[6]);
      e_e[8] <= (64'sd1 <<< 48) - (64'(pd[0]) + 64'(pd[1]));
      deg_e <= deg_d;

      // stage F: round, saturate, force identity on a zero axis with normalize set
      for (int k = 0; k < aar_pkg::ENTRIES; k++) begin
        if (deg_e) begin
          r[k] <= (k % 4 == 0) ? aar_pkg::ONE_Q14 : '0;
        end else begin
          r[k] <= sat16(e_e[k]);
        end
      end
      degenerate <= deg_e;
    end
  end

endmodule
`default_nettype wire

/* src/axis_angle_to_rotation_matrix.sv */
// Axis-angle to 3x3 rotation matrix, Q4.12 in, saturated Q2.14 out.
// Depends on aar_pkg, aar_cordic, aar_sqrt, aar_div, aar_delay, aar_matrix.
//
// Usage:
//   Input items arrive on s_tvalid/s_tready/s_tdata/s_tuser; s_tdata carries
//   axis_x, axis_y, axis_z and angle, s_tuser[0] is the normalize flag.
//   Results leave on m_tvalid/m_tready/m_tdata/m_tuser; m_tdata carries the
//   nine entries r00..r22, m_tuser[0] is the degenerate flag.
//   From acceptance to m_tvalid an item passes two front stages, a 32-stage
//   square root and a 29-stage divider in series (the CORDIC runs beside
//   them), then six matrix stages ending in the output register.
//   Throughput is one item per cycle while m_tready stays high.
//   When the output register holds an item and m_tready is low, the whole
//   pipeline freezes and s_tready drops; nothing is lost or repeated.
//   Synchronous reset clears every valid bit; payload registers are not reset.
//   A zero axis with normalize set gives the identity and sets degenerate.
`default_nettype none
`include "axis_angle_to_rotation_matrix_macros.svh"
module axis_angle_to_rotation_matrix (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          s_tvalid,
  output logic               s_tready,
  input  wire logic [63:0]   s_tdata,   // axis_x, axis_y, axis_z, angle
  input  wire logic [0:0]    s_tuser,   // normalize
  output logic               m_tvalid,
  input  wire logic          m_tready,
  output logic [143:0]       m_tdata,   // r00, r01, r02, r10, r11, r12, r20, r21, r22
  output logic [0:0]         m_tuser    // degenerate
);

  localparam int AW = aar_pkg::AXIS_W;
  localparam int CW = aar_pkg::CORDIC_W;
  localparam int MW = aar_pkg::MAG_W;
  localparam int SIDE_W = $bits(aar_pkg::side_t);

  logic ce;
  logic [aar_pkg::PIPE_DEPTH-1:0] vld;

  // the pipe moves whenever the output register can drain
  assign ce       = !vld[aar_pkg::PIPE_DEPTH-1] || m_tready;
  assign s_tready = ce;
  assign m_tvalid = vld[aar_pkg::PIPE_DEPTH-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (ce) begin
      vld <= {vld[aar_pkg::PIPE_DEPTH-2:0], s_tvalid};
    end
  end

  // stage 0: capture the item
  logic signed [AW-1:0] ax0, ay0, az0, ang0;
  logic                 norm0;

  always_ff @(posedge clk) begin
    if (ce) begin
      ax0   <= s_tdata[15:0];
      ay0   <= s_tdata[31:16];
      az0   <= s_tdata[47:32];
      ang0  <= s_tdata[63:48];
      norm0 <= s_tuser[0];
    end
  end

  // stage 1: squared length, magnitudes, folded half angle
  logic signed [31:0] sqx, sqy, sqz;
  logic signed [CW-1:0] h0;
  logic [aar_pkg::N2_W-1:0] n2_1;
  logic [MW-1:0] mag1 [3];
  logic signed [CW-1:0] z1;
  aar_pkg::side_t side1;

  assign sqx = ax0 * ax0;
  assign sqy = ay0 * ay0;
  assign sqz = az0 * az0;
  assign h0  = {ang0[AW-1], ang0, 15'b0};

  always_ff @(posedge clk) begin
    if (ce) begin
      n2_1    <= 32'(sqx) + 32'(sqy) + 32'(sqz);
      mag1[0] <= ax0[AW-1] ? (~ax0 + 16'd1) : ax0;
      mag1[1] <= ay0[AW-1] ? (~ay0 + 16'd1) : ay0;
      mag1[2] <= az0[AW-1] ? (~az0 + 16'd1) : az0;
      side1.ax    <= ax0;
      side1.ay    <= ay0;
      side1.az    <= az0;
      side1.neg   <= {az0[AW-1], ay0[AW-1], ax0[AW-1]};
      side1.norm  <= norm0;
      side1.degen <= norm0 && (ax0 == '0) && (ay0 == '0) && (az0 == '0);
      if (h0 > aar_pkg::FIX_HALF_PI) begin
        z1         <= h0 - aar_pkg::FIX_PI;
        side1.flip <= 1'b1;
      end else if (h0 < -aar_pkg::FIX_HALF_PI) begin
        z1         <= h0 + aar_pkg::FIX_PI;
        side1.flip <= 1'b1;
      end else begin
        z1         <= h0;
        side1.flip <= 1'b0;
      end
    end
  end

  // CORDIC on the half angle, then line up with the divider output
  logic signed [CW-1:0] cos_c, sin_c, cos_d, sin_d;

  aar_cordic u_cordic (
    .clk     (clk),
    .ce      (ce),
    .z_in    (z1),
    .cos_out (cos_c),
    .sin_out (sin_c)
  );

  aar_delay #(.WIDTH(2 * CW), .DEPTH(aar_pkg::CORDIC_ALIGN)) u_trig_dly (
    .clk  (clk),
    .ce   (ce),
    .din  ({cos_c, sin_c}),
    .dout ({cos_d, sin_d})
  );

  // axis length, then axis over length
  logic [aar_pkg::ROOT_W-1:0] root;
  logic [3*MW-1:0] mag_flat;
  logic [MW-1:0] mag_d [3];
  logic [aar_pkg::QUOT_W-1:0] quot [3];

  aar_sqrt u_sqrt (
    .clk      (clk),
    .ce       (ce),
    .n2       (n2_1),
    .root_out (root)
  );

  aar_delay #(.WIDTH(3 * MW), .DEPTH(aar_pkg::SQRT_STEPS)) u_mag_dly (
    .clk  (clk),
    .ce   (ce),
    .din  ({mag1[2], mag1[1], mag1[0]}),
    .dout (mag_flat)
  );

  assign mag_d[0] = mag_flat[MW-1:0];
  assign mag_d[1] = mag_flat[2*MW-1:MW];
  assign mag_d[2] = mag_flat[3*MW-1:2*MW];

  aar_div u_div (
    .clk  (clk),
    .ce   (ce),
    .len  (root),
    .mag  (mag_d),
    .quot (quot)
  );

  // side information rides beside root and divider
  logic [SIDE_W-1:0] side_flat;
  aar_pkg::side_t side_d;

  aar_delay #(.WIDTH(SIDE_W), .DEPTH(aar_pkg::SIDE_ALIGN)) u_side_dly (
    .clk  (clk),
    .ce   (ce),
    .din  (side1),
    .dout (side_flat)
  );

  assign side_d = side_flat;

  // quaternion and matrix expansion into the output register
  logic signed [aar_pkg::ENTRY_W-1:0] r [aar_pkg::ENTRIES];
  logic degenerate;

  aar_matrix u_matrix (
    .clk        (clk),
    .ce         (ce),
    .quot       (quot),
    .side       (side_d),
    .cos_in     (cos_d),
    .sin_in     (sin_d),
    .r          (r),
    .degenerate (degenerate)
  );

  for (genvar k = 0; k < aar_pkg::ENTRIES; k++) begin : g_pack
    assign m_tdata[k*aar_pkg::ENTRY_W +: aar_pkg::ENTRY_W] = r[k];
  end
  assign m_tuser[0] = degenerate;

  `AAR_ASSERT(a_degen_identity, (m_tvalid && m_tuser[0]) |-> (m_tdata == aar_pkg::IDENTITY_DATA))
  `AAR_ASSERT(a_stall_freezes, (m_tvalid && !m_tready) |=> $stable(vld))
  `AAR_ASSERT_RST(a_reset_empty, rst |=> (vld == '0))

endmodule
`default_nettype wire
